>>> hw/rtl/vector_matrix_product_defines.svh
// Assertion macros for the vector-matrix product top level.
`ifndef VECTOR_MATRIX_PRODUCT_DEFINES_SVH
`define VECTOR_MATRIX_PRODUCT_DEFINES_SVH

// Condition must never hold outside reset.
`define VMP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next, outside reset.
`define VMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Antecedent in one cycle implies consequent in the next, checked through reset too.
`define VMP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/vmp_pkg.sv
// Shared constants and types for the vector-matrix product block.
package vmp_pkg;

   localparam int VECTOR_DEPTH = 1024;
   localparam int ROW_LIMIT    = 4096;

   localparam int ADDR_W    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
   localparam int IN_CNT_W  = $clog2(VECTOR_DEPTH + 1);
   localparam int ROW_W     = (ROW_LIMIT > 1) ? $clog2(ROW_LIMIT) : 1;
   localparam int OUT_CNT_W = $clog2(ROW_LIMIT + 1);

   localparam int VALUE_W    = 16;
   localparam int PROD_W     = 32;
   localparam int DOT_W      = 42;
   localparam int ROW_IDX_W  = 12;
   localparam int IN_SIZE_W  = 11;
   localparam int OUT_SIZE_W = 13;

   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IN_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_SIZE = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      REQ_VECTOR = 1'b0,
      REQ_MATRIX = 1'b1
   } req_kind_type;

   // One matrix element with its vector operand, ready for the MAC.
   typedef struct packed {
      logic signed [VALUE_W-1:0]  vec;
      logic signed [VALUE_W-1:0]  mat;
      logic                       row_end;
      logic [ROW_IDX_W-1:0]       row_idx;
      logic                       last;
   } queue_entry_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } queue_status_type;

endpackage

>>> hw/rtl/vmp_ram.sv
// Generic simple dual-port RAM with registered read.
module vmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  logic [WIDTH-1:0]                  wr_data,
   input  logic                              rd_en,
   input  logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic [WIDTH-1:0]                  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/vmp_queue.sv
// Small FIFO between the request front end and the MAC back end.
module vmp_queue import vmp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  queue_entry_type  push_entry,
   input  logic             pop,
   output queue_entry_type  head_entry,
   output queue_status_type status
);

   queue_entry_type   slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

>>> hw/rtl/vmp_front.sv
// Front end: takes requests, owns the vector store and the row/column counters.
module vmp_front import vmp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_type,
   input  logic signed [VALUE_W-1:0]     req_value,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  queue_status_type              q_status,
   output logic                          q_push,
   output queue_entry_type               q_entry
);

   logic [IN_SIZE_W-1:0]  in_size_ff, in_size_in;
   logic [OUT_SIZE_W-1:0] out_size_ff, out_size_in;
   logic [ADDR_W-1:0]     load_ff, load_in;
   logic [ADDR_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;

   // Issue stage, lined up with the RAM read data.
   logic                          stg_valid_ff, stg_valid_in;
   logic signed [VALUE_W-1:0]     stg_mat_ff;
   logic                          stg_row_end_ff;
   logic [ROW_IDX_W-1:0]          stg_row_idx_ff;
   logic                          stg_last_ff;

   logic [IN_CNT_W-1:0]   n_in;
   logic [OUT_CNT_W-1:0]  n_out;
   logic [QCNT_W:0]       pending;
   logic                  accept, is_vec, is_mat;
   logic [ADDR_W-1:0]     load_pos, col_pos;
   logic [IN_CNT_W-1:0]   load_next, col_next;
   logic [OUT_CNT_W-1:0]  row_next;
   logic                  row_end, batch_last;
   logic [VALUE_W-1:0]    ram_rd_data;

   // Clamp the size registers to their usable ranges.
   always_comb begin
      if (in_size_ff == '0) begin
         n_in = IN_CNT_W'(1);
      end else if (32'(in_size_ff) > 32'(VECTOR_DEPTH)) begin
         n_in = IN_CNT_W'(VECTOR_DEPTH);
      end else begin
         n_in = IN_CNT_W'(in_size_ff);
      end
      if (out_size_ff == '0) begin
         n_out = OUT_CNT_W'(1);
      end else if (32'(out_size_ff) > 32'(ROW_LIMIT)) begin
         n_out = OUT_CNT_W'(ROW_LIMIT);
      end else begin
         n_out = OUT_CNT_W'(out_size_ff);
      end
   end

   // Room for this request and the one already in the issue stage.
   assign pending   = (QCNT_W + 1)'(q_status.count) + (QCNT_W + 1)'(stg_valid_ff);
   assign req_ready = (pending < (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && req_ready;
   assign is_vec    = accept && (req_type == REQ_VECTOR);
   assign is_mat    = accept && (req_type == REQ_MATRIX);

   always_comb begin
      load_pos   = (IN_CNT_W'(load_ff) >= n_in) ? '0 : load_ff;
      load_next  = IN_CNT_W'(load_pos) + 1'b1;
      col_pos    = (32'(col_ff) >= 32'(VECTOR_DEPTH)) ? '0 : col_ff;
      col_next   = IN_CNT_W'(col_pos) + 1'b1;
      row_end    = (col_next >= n_in);
      row_next   = OUT_CNT_W'(row_ff) + 1'b1;
      batch_last = (row_next >= n_out);

      load_in = load_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      if (is_vec) begin
         load_in = (load_next >= n_in) ? '0 : ADDR_W'(load_next);
      end
      if (is_mat) begin
         if (row_end) begin
            col_in = '0;
            row_in = batch_last ? '0 : ROW_W'(row_next);
         end else begin
            col_in = ADDR_W'(col_next);
         end
      end

      in_size_in  = in_size_ff;
      out_size_in = out_size_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_IN_SIZE:  in_size_in  = IN_SIZE_W'(csr_data);
            CSR_OUT_SIZE: out_size_in = csr_data;
            default: ;
         endcase
      end

      stg_valid_in = is_mat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_size_ff   <= IN_SIZE_W'(1);
         out_size_ff  <= OUT_SIZE_W'(1);
         load_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         in_size_ff   <= in_size_in;
         out_size_ff  <= out_size_in;
         load_ff      <= load_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_mat) begin
         stg_mat_ff     <= req_value;
         stg_row_end_ff <= row_end;
         stg_row_idx_ff <= ROW_IDX_W'(row_ff);
         stg_last_ff    <= row_end && batch_last;
      end
   end

   vmp_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (is_vec),
      .wr_addr (load_pos),
      .wr_data (req_value),
      .rd_en   (is_mat),
      .rd_addr (col_pos),
      .rd_data (ram_rd_data)
   );

   assign q_push          = stg_valid_ff;
   assign q_entry.vec     = $signed(ram_rd_data);
   assign q_entry.mat     = stg_mat_ff;
   assign q_entry.row_end = stg_row_end_ff;
   assign q_entry.row_idx = stg_row_idx_ff;
   assign q_entry.last    = stg_last_ff;

endmodule

>>> hw/rtl/vmp_back.sv
// Back end: multiply, accumulate, and hold the response register.
module vmp_back import vmp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  queue_entry_type             head_entry,
   input  queue_status_type            q_status,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DOT_W-1:0]     rsp_dot_value,
   output logic [ROW_IDX_W-1:0]        rsp_row_index,
   output logic                        rsp_batch_last
);

   logic                        p_valid_ff, p_valid_in;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        p_row_end_ff;
   logic [ROW_IDX_W-1:0]        p_row_idx_ff;
   logic                        p_last_ff;

   logic signed [DOT_W-1:0]     acc_ff, acc_in;
   logic                        out_valid_ff, out_valid_in;
   logic signed [DOT_W-1:0]     out_dot_ff;
   logic [ROW_IDX_W-1:0]        out_row_ff;
   logic                        out_last_ff;

   logic                        advance;
   logic signed [DOT_W-1:0]     sum;
   logic                        emit;

   // Pipeline moves unless a finished row waits on a stalled consumer.
   assign advance = !(out_valid_ff && !rsp_ready);
   assign q_pop   = advance && !q_status.empty;
   assign sum     = acc_ff + DOT_W'(prod_ff);
   assign emit    = advance && p_valid_ff && p_row_end_ff;

   always_comb begin
      p_valid_in   = p_valid_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         p_valid_in   = q_pop;
         out_valid_in = p_valid_ff && p_row_end_ff;
         if (p_valid_ff) begin
            acc_in = p_row_end_ff ? '0 : sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         prod_ff      <= head_entry.vec * head_entry.mat;
         p_row_end_ff <= head_entry.row_end;
         p_row_idx_ff <= head_entry.row_idx;
         p_last_ff    <= head_entry.last;
      end
      if (emit) begin
         out_dot_ff  <= sum;
         out_row_ff  <= p_row_idx_ff;
         out_last_ff <= p_last_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_dot_value  = out_dot_ff;
   assign rsp_row_index  = out_row_ff;
   assign rsp_batch_last = out_last_ff;

endmodule

>>> hw/rtl/vector_matrix_product.sv
// Top level of the Q8.8 vector-matrix product (dense layer forward) block.
//
// Usage: write in_size (csr index 0) and out_size (index 1) while idle, then
// stream in_size vector requests (req_type 0) followed by out_size rows of
// in_size matrix requests (req_type 1) in row-major order. Each finished row
// returns one response: the exact dot product with 16 fractional bits
// (wrapping modulo 2^42), the row index, and batch_last on the final row.
// Sizes are clamped to 1..1024 and 1..4096; zero acts as one. The vector
// store is a 1024-entry RAM with no clearing pass; reading an entry never
// loaded gives an unspecified value. Throughput is one request per cycle,
// vector or matrix, as long as rsp_ready stays high. A matrix element passes
// the RAM read, the queue and the multiply register on its way to the
// accumulator; a row's response register takes the sum with its last product.
// A four-entry queue separates the front end (RAM and counters) from the MAC
// back end; req_ready drops only when that queue, with the issue stage, fills
// behind a stalled response port.
module vector_matrix_product import vmp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_type,
   input  logic signed [VALUE_W-1:0]   req_value,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DOT_W-1:0]     rsp_dot_value,
   output logic [ROW_IDX_W-1:0]        rsp_row_index,
   output logic                        rsp_batch_last,
   // configuration writes
   input  logic                        csr_write,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

`include "vector_matrix_product_defines.svh"

   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_over;

   // Front end: vector RAM, load/column/row counters, size registers.
   vmp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .req_value (req_value),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // Decoupling queue of operand pairs.
   vmp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   // Back end: registered multiply, 42-bit accumulate, response register.
   vmp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_status       (q_status),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dot_value  (rsp_dot_value),
      .rsp_row_index  (rsp_row_index),
      .rsp_batch_last (rsp_batch_last)
   );

   assign q_full = (q_status.count == QCNT_W'(QUEUE_DEPTH));
   assign q_over = (q_status.count > QCNT_W'(QUEUE_DEPTH));

   // Queue never holds more than its depth.
   `VMP_ASSERT_NEVER(a_queue_bound, clock, reset, q_over, "operand queue overflow")
   // No push into a full queue unless it pops in the same cycle.
   `VMP_ASSERT_NEVER(a_no_push_full, clock, reset, q_push && !q_pop && q_full, "push when full")
   // A full queue must hold off new requests.
   `VMP_ASSERT_NEVER(a_ready_full, clock, reset, req_ready && q_full, "ready while queue full")
   // Reset leaves no response pending.
   `VMP_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && q_status.empty, "not idle")

endmodule

>>> bench/tb_vector_matrix_product.sv
// Self-checking testbench for the Q8.8 vector-matrix product block.
module tb_vector_matrix_product;
   import vmp_pkg::*;

   // Run constants
   localparam int RANDOM_ITEMS  = 850;     // random requests before the run winds down
   localparam int DRAIN_CYCLES  = 16;      // lets the pipeline empty, with margin
   localparam int HOLD_CYCLES   = 300;     // long receiver hold-off, fills the queue
   localparam int STEP_COUNT    = 29;      // rows in the directed table

   // One expected response
   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [ROW_IDX_W-1:0]    row;
      logic                    last;
   } dot_result_type;

   // Directed table row: either a register write or a request
   typedef enum logic {
      STEP_REQ = 1'b0,
      STEP_CSR = 1'b1
   } step_kind_type;

   typedef struct packed {
      step_kind_type           kind;
      logic                    sel;      // request type, or register index
      logic [15:0]             data;     // request value, or register data
      logic                    typed;    // expected response given in the row
      logic signed [DOT_W-1:0] dot;
      logic [ROW_IDX_W-1:0]    row;
      logic                    last;
   } directed_step_type;

   // Clock, reset and DUT ports; every input known from time zero
   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic                        req_type       = 1'b0;
   logic signed [VALUE_W-1:0]   req_value      = '0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic signed [DOT_W-1:0]     rsp_dot_value;
   logic [ROW_IDX_W-1:0]        rsp_row_index;
   logic                        rsp_batch_last;
   logic                        csr_write      = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index      = '0;
   logic [CSR_DATA_W-1:0]       csr_data       = '0;

   // Predictor state: the bench's own copy of the datapath
   logic [VALUE_W-1:0]    vec_entries [VECTOR_DEPTH];
   bit                    entry_loaded [VECTOR_DEPTH];   // guards against unwritten reads
   int                    load_ptr   = 0;
   int                    col_ptr    = 0;
   int                    row_ptr    = 0;
   logic [DOT_W-1:0]      row_sum    = '0;
   logic [IN_SIZE_W-1:0]  in_size_reg  = 11'd1;
   logic [OUT_SIZE_W-1:0] out_size_reg = 13'd1;

   dot_result_type    pending_dots [$];      // responses still owed by the DUT
   directed_step_type directed_steps [0:STEP_COUNT-1];
   int             mismatches  = 0;
   int             burst_left  = 0;
   bit             hold_go     = 1'b0;
   bit             hold_done   = 1'b0;

   vector_matrix_product dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_dot_value  (rsp_dot_value),
      .rsp_row_index  (rsp_row_index),
      .rsp_batch_last (rsp_batch_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 10-unit clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Effective sizes: zero acts as one, large values clamp to the array bounds
   function automatic int clamp_in(input logic [IN_SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > VECTOR_DEPTH) return VECTOR_DEPTH;
      return int'(v);
   endfunction

   function automatic int clamp_out(input logic [OUT_SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > ROW_LIMIT) return ROW_LIMIT;
      return int'(v);
   endfunction

   // Advance the datapath model by one accepted request.
   // Returns 1 when a row finishes, with the row's response in res.
   function automatic bit advance_product(input req_kind_type kind,
                                          input logic [VALUE_W-1:0] value,
                                          output dot_result_type res);
      int n_in;
      int n_out;
      int pos;
      int col;
      logic signed [PROD_W-1:0] prod;
      res   = '0;
      n_in  = clamp_in(in_size_reg);
      n_out = clamp_out(out_size_reg);
      if (kind == REQ_VECTOR) begin
         // vector load wraps after n_in entries; a stale pointer restarts at 0
         pos = (load_ptr >= n_in) ? 0 : load_ptr;
         vec_entries[pos]  = value;
         entry_loaded[pos] = 1'b1;
         pos++;
         load_ptr = (pos >= n_in) ? 0 : pos;
         return 1'b0;
      end
      col  = (col_ptr >= VECTOR_DEPTH) ? 0 : col_ptr;
      prod = $signed(vec_entries[col]) * $signed(value);      // exact Q16.16
      row_sum = row_sum + {{(DOT_W-PROD_W){prod[PROD_W-1]}}, prod};
      col++;
      if (col < n_in) begin
         col_ptr = col;
         return 1'b0;
      end
      // row done; a column count at or past a shrunk bound also lands here
      res.dot  = row_sum;
      res.row  = row_ptr[ROW_IDX_W-1:0];
      res.last = (row_ptr + 1 >= n_out);
      row_sum  = '0;
      col_ptr  = 0;
      row_ptr  = res.last ? 0 : row_ptr + 1;
      return 1'b1;
   endfunction

   // Mix of corner values and fully random Q8.8 values
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Idle step: nothing offered and no register write
   task automatic idle_cycle();
      @(negedge clock);
      req_valid <= 1'b0;
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Register write; only issued while the DUT is idle
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      if (idx == CSR_IN_SIZE) in_size_reg = data[IN_SIZE_W-1:0];
      else out_size_reg = data[OUT_SIZE_W-1:0];
   endtask

   // Offer one request, in bursts with random gaps, and predict its response.
   // During the long receiver hold-off there are no gaps, so the DUT backs up.
   task automatic send_request(input req_kind_type kind,
                               input logic [VALUE_W-1:0] value,
                               input bit typed,
                               input dot_result_type typed_res,
                               output bit emitted,
                               output dot_result_type res);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         while (gap > 0 && !(hold_go && !hold_done)) begin
            idle_cycle();
            gap--;
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      csr_write <= 1'b0;
      req_type  <= kind;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      emitted = advance_product(kind, value, res);
      if (emitted) pending_dots.push_back(typed ? typed_res : res);
   endtask

   // Wait for every owed response, then let the pipeline empty out
   task automatic drain_pipeline();
      while (pending_dots.size() != 0) idle_cycle();
      repeat (DRAIN_CYCLES) idle_cycle();
   endtask

   // A stretch of traffic: mostly a vector load followed by matrix rows,
   // with stray vector requests and early matrix requests mixed in unless clean.
   task automatic run_phase(input int count, input bit clean);
      int k;
      int r;
      int col;
      int load_left;
      req_kind_type kind;
      bit emitted;
      dot_result_type res;
      dot_result_type none;
      none      = '0;
      load_left = clamp_in(in_size_reg);
      for (k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (!clean && r < 4) begin
            kind = REQ_VECTOR;                    // noise: stray vector element
         end else if (load_left > 0 && (clean || r >= 8)) begin
            kind = REQ_VECTOR;
            load_left--;
         end else begin
            kind = REQ_MATRIX;                    // may cut a load short
         end
         // never read a vector entry that was not loaded
         col = (col_ptr >= VECTOR_DEPTH) ? 0 : col_ptr;
         if (kind == REQ_MATRIX && !entry_loaded[col]) kind = REQ_VECTOR;
         send_request(kind, pick_value(), 1'b0, none, emitted, res);
         // new batch, new vector
         if (emitted && res.last) load_left = clamp_in(in_size_reg);
      end
   endtask

   // Receiver: random stall patterns, plus one long hold-off on request
   initial begin : rsp_stall_pattern
      int mode;
      int left;
      int tick;
      int hold_count;
      mode       = 0;
      left       = 0;
      tick       = 0;
      hold_count = 0;
      forever begin
         @(negedge clock);
         tick++;
         if (hold_go && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               0: rsp_ready <= 1'b1;                              // no stalls
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);       // mostly stalled
               default: rsp_ready <= ((tick % 5) < 2);            // periodic
            endcase
         end
      end
   end

   // Response checker: in order, field by field, against the oldest expectation
   always @(posedge clock) begin : rsp_check
      dot_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dots.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual dot %0d row %0d last %0b",
                     $time, rsp_dot_value, rsp_row_index, rsp_batch_last);
            mismatches++;
         end else begin
            want = pending_dots.pop_front();
            if (rsp_dot_value !== want.dot) begin
               $display("%0t: dot_value expected %0d actual %0d",
                        $time, want.dot, rsp_dot_value);
               mismatches++;
            end
            if (rsp_row_index !== want.row) begin
               $display("%0t: row_index expected %0d actual %0d",
                        $time, want.row, rsp_row_index);
               mismatches++;
            end
            if (rsp_batch_last !== want.last) begin
               $display("%0t: batch_last expected %0b actual %0b",
                        $time, want.last, rsp_batch_last);
               mismatches++;
            end
         end
      end
   end

   // Stimulus: directed table, one long-row phase, then random phases
   initial begin : stimulus
      int i;
      int random_items;
      int n;
      int which;
      bit emitted;
      dot_result_type res;
      dot_result_type noted;
      logic [CSR_DATA_W-1:0] in_w;
      logic [CSR_DATA_W-1:0] out_w;

      // Directed rows. Sizes start at 1/1, so each matrix element closes a
      // one-row batch and its response can be written down directly.
      directed_steps = '{
         '{STEP_REQ, REQ_VECTOR, 16'h0100, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h0100, 1'b1, 42'sd65536, 12'd0, 1'b1},       // 1.0 * 1.0
         '{STEP_REQ, REQ_VECTOR, 16'h8000, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h8000, 1'b1, 42'sd1073741824, 12'd0, 1'b1},  // min * min
         '{STEP_REQ, REQ_VECTOR, 16'h7FFF, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h8000, 1'b1, -42'sd1073709056, 12'd0, 1'b1}, // max * min
         '{STEP_REQ, REQ_VECTOR, 16'h7FFF, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h7FFF, 1'b1, 42'sd1073676289, 12'd0, 1'b1},  // max * max
         '{STEP_REQ, REQ_VECTOR, 16'h0000, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h1234, 1'b1, 42'sd0, 12'd0, 1'b1},           // zero operand
         '{STEP_CSR, CSR_IN_SIZE,  16'd4, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_CSR, CSR_OUT_SIZE, 16'd3, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_VECTOR, 16'hFFFF, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_VECTOR, 16'h0001, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_VECTOR, 16'h8000, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_VECTOR, 16'h7FFF, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h7FFF, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h8000, 1'b0, 42'sd0, 12'd0, 1'b0},
         // shrink row length mid-row: column 2 now meets the bound
         '{STEP_CSR, CSR_IN_SIZE,  16'd2, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'hFFFF, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h0001, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h0002, 1'b0, 42'sd0, 12'd0, 1'b0},
         // shrink batch mid-batch: row 2 is already past the bound
         '{STEP_CSR, CSR_OUT_SIZE, 16'd2, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h0100, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'hFF00, 1'b0, 42'sd0, 12'd0, 1'b0},
         // zero sizes act as one
         '{STEP_CSR, CSR_IN_SIZE,  16'd0, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_CSR, CSR_OUT_SIZE, 16'd0, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h4000, 1'b0, 42'sd0, 12'd0, 1'b0},
         '{STEP_REQ, REQ_MATRIX, 16'h8000, 1'b0, 42'sd0, 12'd0, 1'b0}
      };

      // Synchronous reset, released on a falling clock edge
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < STEP_COUNT; i++) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            drain_pipeline();
            write_register(directed_steps[i].sel, directed_steps[i].data[CSR_DATA_W-1:0]);
         end else begin
            noted.dot  = directed_steps[i].dot;
            noted.row  = directed_steps[i].row;
            noted.last = directed_steps[i].last;
            send_request(req_kind_type'(directed_steps[i].sel), directed_steps[i].data,
                         directed_steps[i].typed, noted, emitted, res);
         end
      end

      // Long row: half-depth vector, one row
      drain_pipeline();
      write_register(CSR_IN_SIZE, 13'(VECTOR_DEPTH / 2));
      write_register(CSR_OUT_SIZE, 13'd1);
      run_phase(VECTOR_DEPTH, 1'b1);

      // Random phases; sizes mostly small, now and then zero or out of range
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         drain_pipeline();
         case ($urandom_range(0, 19))
            0:       in_w = '0;
            1:       in_w = 13'($urandom_range(0, 8191));    // upper bits dropped by the 11-bit size register
            2, 3, 4: in_w = 13'($urandom_range(9, 40));
            default: in_w = 13'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 19))
            0:       out_w = '0;
            1:       out_w = 13'($urandom_range(0, 8191));
            2, 3, 4: out_w = 13'($urandom_range(7, 30));
            default: out_w = 13'($urandom_range(1, 6));
         endcase
         // a stale column past the new bound must point at a loaded entry
         if (col_ptr >= clamp_in(in_w[IN_SIZE_W-1:0]) && !entry_loaded[col_ptr])
            in_w = 13'(col_ptr + 1);
         which = $urandom_range(0, 3);
         if (which != 1) write_register(CSR_IN_SIZE, in_w);
         if (which != 0) write_register(CSR_OUT_SIZE, out_w);
         // once, on a short-row setting, hold the receiver off for a long time
         if (!hold_go && clamp_in(in_size_reg) <= 4) hold_go = 1'b1;
         n = clamp_in(in_size_reg) + $urandom_range(20, 120);
         run_phase(n, 1'b0);
         random_items += n;
      end

      drain_pipeline();
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, well beyond the slowest legal run
   initial begin : watchdog
      #20000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
